[rtl/core/psr_pkg.sv]
// shared constants, widths and the arctangent table for the principal stress resolver
package psr_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 8;
    localparam int ANG_W         = FRAC_BITS + 2;
    localparam int THR_W         = 16;
    localparam int DIFF_W        = DATA_W + 1;
    localparam int XY_W          = DATA_W + GUARD_BITS + 4;
    localparam int Z_W           = 34;
    localparam int PIPE_DEPTH    = CORDIC_STAGES + 3;
    localparam int MAG_W         = XY_W - 1;
    localparam int HI_W          = MAG_W - 30;
    localparam int PH_W          = HI_W + 30;
    localparam int M_W           = PH_W + 1 - GUARD_BITS;
    localparam int T_W           = M_W + 2;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'sd1686629713);
    localparam logic [29:0]           INV_GAIN_Q30 = 30'd652032874;
    localparam int ANG_LIM =
        (1686629713 + (1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam int ROUND_SH = 31 - FRAC_BITS;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ANG_W-1:0]  t_angle;
    typedef logic [THR_W-1:0]         t_thr;
    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [Z_W-1:0]    t_z;

    function automatic t_z atan_q30(input logic [4:0] idx);
        t_z r;
        unique case (idx)
            5'd0:  r = Z_W'(843314856);
            5'd1:  r = Z_W'(497837829);
            5'd2:  r = Z_W'(263043836);
            5'd3:  r = Z_W'(133525158);
            5'd4:  r = Z_W'(67021686);
            5'd5:  r = Z_W'(33543515);
            5'd6:  r = Z_W'(16775850);
            5'd7:  r = Z_W'(8388437);
            5'd8:  r = Z_W'(4194282);
            5'd9:  r = Z_W'(2097149);
            5'd10: r = Z_W'(1048575);
            5'd11: r = Z_W'(524287);
            5'd12: r = Z_W'(262143);
            5'd13: r = Z_W'(131071);
            5'd14: r = Z_W'(65535);
            5'd15: r = Z_W'(32767);
            5'd16: r = Z_W'(16383);
            5'd17: r = Z_W'(8191);
            5'd18: r = Z_W'(4095);
            5'd19: r = Z_W'(2047);
            5'd20: r = Z_W'(1023);
            5'd21: r = Z_W'(511);
            5'd22: r = Z_W'(255);
            5'd23: r = Z_W'(127);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/psr_if.sv]
// handshake channels: tensor input, principal result output, threshold write
interface psr_in_if;
    import psr_pkg::*;
    logic  valid;
    logic  ready;
    t_data moment_x;
    t_data moment_y;
    t_data moment_xy;
    t_data force_x;
    t_data force_y;
    t_data force_xy;
    modport source (output valid, moment_x, moment_y, moment_xy,
                    force_x, force_y, force_xy, input ready);
    modport sink   (input valid, moment_x, moment_y, moment_xy,
                    force_x, force_y, force_xy, output ready);
endinterface

interface psr_out_if;
    import psr_pkg::*;
    logic   valid;
    logic   ready;
    t_data  moment_major;
    t_data  moment_minor;
    t_angle moment_angle;
    t_data  force_major;
    t_data  force_minor;
    t_angle force_angle;
    modport source (output valid, moment_major, moment_minor, moment_angle,
                    force_major, force_minor, force_angle, input ready);
    modport sink   (input valid, moment_major, moment_minor, moment_angle,
                    force_major, force_minor, force_angle, output ready);
endinterface

interface psr_cfg_if;
    import psr_pkg::*;
    logic valid;
    logic ready;
    t_thr data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/psr_tensor.sv]
// one tensor datapath: difference, vectoring cordic, gain multiply, principal values
module psr_tensor (
    input  logic                                i_clk,
    input  logic [psr_pkg::PIPE_DEPTH-1:0]      i_en,
    input  psr_pkg::t_thr                       i_thr,
    input  psr_pkg::t_data                      i_a,
    input  psr_pkg::t_data                      i_b,
    input  psr_pkg::t_data                      i_s,
    output psr_pkg::t_data                      o_major,
    output psr_pkg::t_data                      o_minor,
    output psr_pkg::t_angle                     o_angle
);
    import psr_pkg::*;

    localparam int MUL_IDX = CORDIC_STAGES + 1;
    localparam int FIN_IDX = CORDIC_STAGES + 2;

    t_xy                     r_x   [CORDIC_STAGES+1];
    t_xy                     r_y   [CORDIC_STAGES+1];
    t_z                      r_z   [CORDIC_STAGES+1];
    logic signed [DIFF_W-1:0] r_sum [CORDIC_STAGES+1];
    logic                    r_flg [CORDIC_STAGES+1];

    // stage 0: difference, threshold test, quadrant fold
    logic signed [DIFF_W-1:0] n_d, n_sum;
    logic [DIFF_W-1:0]        n_absd;
    t_xy                      n_x0, n_y0;

    always_comb begin
        n_d    = DIFF_W'(i_a) - DIFF_W'(i_b);
        n_sum  = DIFF_W'(i_a) + DIFF_W'(i_b);
        n_absd = n_d[DIFF_W-1] ? DIFF_W'(-n_d) : DIFF_W'(n_d);
        n_x0   = XY_W'(n_d) <<< GUARD_BITS;
        n_y0   = XY_W'(i_s) <<< (GUARD_BITS + 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum[0] <= n_sum;
            r_flg[0] <= n_absd > DIFF_W'(i_thr);
            if (n_x0 < 0) begin
                if (n_y0 >= 0) begin
                    r_x[0] <= n_y0;
                    r_y[0] <= -n_x0;
                    r_z[0] <= HALF_PI_Q30;
                end else begin
                    r_x[0] <= -n_y0;
                    r_y[0] <= n_x0;
                    r_z[0] <= -HALF_PI_Q30;
                end
            end else begin
                r_x[0] <= n_x0;
                r_y[0] <= n_y0;
                r_z[0] <= '0;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en[g+1]) begin
                r_sum[g+1] <= r_sum[g];
                r_flg[g+1] <= r_flg[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(5'(g));
                end
            end
        end
    end

    // gain correction split into high and low partial products
    logic [MAG_W-1:0]         n_u;
    logic [59:0]              n_pl_full;
    logic [PH_W-1:0]          r_ph;
    logic [29:0]              r_pl;
    logic signed [DIFF_W-1:0] r_sum_m;
    logic                     r_flg_m;
    t_z                       r_z_m;

    always_comb begin
        n_u       = (r_x[CORDIC_STAGES] > 0) ? MAG_W'(r_x[CORDIC_STAGES]) : '0;
        n_pl_full = 60'(n_u[29:0]) * 60'(INV_GAIN_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[MUL_IDX]) begin
            r_ph    <= PH_W'(n_u[MAG_W-1:30]) * PH_W'(INV_GAIN_Q30);
            r_pl    <= n_pl_full[59:30];
            r_sum_m <= r_sum[CORDIC_STAGES];
            r_flg_m <= r_flg[CORDIC_STAGES];
            r_z_m   <= r_z[CORDIC_STAGES];
        end
    end

    // final: diameter rounding, mean +/- radius with saturation, angle
    localparam logic signed [T_W-1:0] SAT_HI = T_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [T_W-1:0] SAT_LO = -SAT_HI - T_W'(1);
    localparam logic signed [Z_W-1:0] LIM_Z  = Z_W'(ANG_LIM);

    logic [PH_W:0]          n_p;
    logic [M_W-1:0]         n_m;
    logic signed [T_W-1:0]  n_tmaj, n_tmin;
    t_z                     n_zr;
    t_z                     n_ang;
    t_data                  r_major, r_minor;
    t_angle                 r_angle;

    always_comb begin
        n_p    = (PH_W+1)'(r_ph) + (PH_W+1)'(r_pl) + (PH_W+1)'(1 << (GUARD_BITS - 1));
        n_m    = n_p[PH_W:GUARD_BITS];
        n_tmaj = (T_W'(r_sum_m) + $signed(T_W'({1'b0, n_m})) + T_W'(1)) >>> 1;
        n_tmin = (T_W'(r_sum_m) - $signed(T_W'({1'b0, n_m})) + T_W'(1)) >>> 1;
        n_zr   = (r_z_m + Z_W'(1 << (ROUND_SH - 1))) >>> ROUND_SH;
        if (!r_flg_m)          n_ang = '0;
        else if (n_zr > LIM_Z) n_ang = LIM_Z;
        else if (n_zr < -LIM_Z) n_ang = -LIM_Z;
        else                   n_ang = n_zr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[FIN_IDX]) begin
            r_major <= (n_tmaj > SAT_HI) ? DATA_W'(SAT_HI) :
                       (n_tmaj < SAT_LO) ? DATA_W'(SAT_LO) : DATA_W'(n_tmaj);
            r_minor <= (n_tmin > SAT_HI) ? DATA_W'(SAT_HI) :
                       (n_tmin < SAT_LO) ? DATA_W'(SAT_LO) : DATA_W'(n_tmin);
            r_angle <= ANG_W'(n_ang);
        end
    end

    assign o_major = r_major;
    assign o_minor = r_minor;
    assign o_angle = r_angle;

endmodule

[rtl/core/principal_stress_resolver.sv]
// pipeline from input transfer to result: quadrant fold, 16 cordic stages,
// gain multiply, output stage; one item per cycle while the output is not stalled
// each stage holds or advances on its own, so bubbles close up during a stall
// and the last stage is the output register
// synchronous active-low reset clears stage valid bits and sets the threshold to 1
module principal_stress_resolver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psr_in_if.sink        i_in,
    psr_cfg_if.sink       i_cfg,
    psr_out_if.source     o_out
);
    import psr_pkg::*;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_en;
    t_thr                  r_thr;

    always_comb begin
        n_en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || o_out.ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= THR_W'(1);
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.data;
            end
            if (n_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = n_en[0];
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_vld[PIPE_DEPTH-1];

    psr_tensor u_moment (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_thr   (r_thr),
        .i_a     (i_in.moment_x),
        .i_b     (i_in.moment_y),
        .i_s     (i_in.moment_xy),
        .o_major (o_out.moment_major),
        .o_minor (o_out.moment_minor),
        .o_angle (o_out.moment_angle)
    );

    psr_tensor u_force (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_thr   (r_thr),
        .i_a     (i_in.force_x),
        .i_b     (i_in.force_y),
        .i_s     (i_in.force_xy),
        .o_major (o_out.force_major),
        .o_minor (o_out.force_minor),
        .o_angle (o_out.force_angle)
    );

endmodule

[rtl/core/psr_checker.sv]
// port-level checks on the principal stress resolver, bound to the top level
module psr_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input psr_pkg::t_data        i_m_major,
    input psr_pkg::t_data        i_m_minor,
    input psr_pkg::t_angle       i_m_angle,
    input psr_pkg::t_data        i_f_major,
    input psr_pkg::t_data        i_f_minor
);
    import psr_pkg::*;

    localparam logic signed [ANG_W-1:0] LIM_A = ANG_W'(ANG_LIM);

    // an empty output stage means the whole pipe can take a transfer
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_m_major)
            && $stable(i_f_minor))
        else $error("stalled result changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_m_major >= i_m_minor) && (i_f_major >= i_f_minor))
        else $error("major below minor");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_m_angle <= LIM_A) && (i_m_angle >= -LIM_A))
        else $error("angle out of range");

endmodule

bind principal_stress_resolver psr_checker u_psr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_m_major   (o_out.moment_major),
    .i_m_minor   (o_out.moment_minor),
    .i_m_angle   (o_out.moment_angle),
    .i_f_major   (o_out.force_major),
    .i_f_minor   (o_out.force_minor)
);

[bench/psr_checker.sv]
// checker: watches the resolver channels, predicts principal values and compares
module tb_psr_checker
    import psr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    psr_in_if     in_ch,
    psr_out_if    out_ch,
    psr_cfg_if    cfg_ch,
    output int    o_errors,
    output int    o_pending,
    output int    o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_data  major;
        t_data  minor;
        t_angle angle;
    } t_principal;

    typedef struct packed {
        t_principal moment;
        t_principal membrane;
    } t_result;

    t_result expected_q[$];
    t_thr    threshold;

    // arctangent table in Q30, same constants as the hardware uses
    localparam longint ATAN_TAB [0:15] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767};
    localparam longint HALF_PI = 1686629713;
    localparam longint INV_GAIN = 652032874;

    function automatic t_principal principal_of(t_data a, t_data b, t_data s, t_thr thr);
        longint d, sum, x, y, z, t, dx, dy, m, mj, mn, ang, lim, ad;
        longint unsigned u, p;
        t_principal r;
        d = longint'(a) - longint'(b);
        sum = longint'(a) + longint'(b);
        x = d <<< GUARD_BITS;
        y = longint'(s) <<< (GUARD_BITS + 1);
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        u = (x > 0) ? longint'(x) : 0;
        p = (u >> 30) * INV_GAIN + (((u & 64'h3FFF_FFFF) * INV_GAIN) >> 30);
        m = longint'((p + (1 << (GUARD_BITS - 1))) >> GUARD_BITS);
        mj = (sum + m + 1) >>> 1;
        mn = (sum - m + 1) >>> 1;
        if (mj > 64'sh7FFF_FFFF) mj = 64'sh7FFF_FFFF;
        if (mj < -64'sh8000_0000) mj = -64'sh8000_0000;
        if (mn > 64'sh7FFF_FFFF) mn = 64'sh7FFF_FFFF;
        if (mn < -64'sh8000_0000) mn = -64'sh8000_0000;
        ang = 0;
        ad = (d < 0) ? -d : d;
        if (ad > longint'(thr)) begin
            lim = (HALF_PI + (1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            ang = (z + (1 << (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
            if (ang > lim) ang = lim;
            if (ang < -lim) ang = -lim;
        end
        r.major = t_data'(mj);
        r.minor = t_data'(mn);
        r.angle = t_angle'(ang);
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            threshold <= t_thr'(1);
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                threshold <= cfg_ch.data;
            if (in_ch.valid && in_ch.ready) begin
                e.moment = principal_of(in_ch.moment_x, in_ch.moment_y, in_ch.moment_xy,
                                        threshold);
                e.membrane = principal_of(in_ch.force_x, in_ch.force_y, in_ch.force_xy,
                                          threshold);
                expected_q.push_back(e);
            end
            if (out_ch.valid && out_ch.ready) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if ({out_ch.moment_major, out_ch.moment_minor, out_ch.moment_angle,
                         out_ch.force_major, out_ch.force_minor, out_ch.force_angle}
                        !== e) begin
                        o_errors <= o_errors + 1;
                        if (out_ch.moment_major !== e.moment.major)
                            $error("moment_major exp %0d got %0d", e.moment.major,
                                   out_ch.moment_major);
                        if (out_ch.moment_minor !== e.moment.minor)
                            $error("moment_minor exp %0d got %0d", e.moment.minor,
                                   out_ch.moment_minor);
                        if (out_ch.moment_angle !== e.moment.angle)
                            $error("moment_angle exp %0d got %0d", e.moment.angle,
                                   out_ch.moment_angle);
                        if (out_ch.force_major !== e.membrane.major)
                            $error("force_major exp %0d got %0d", e.membrane.major,
                                   out_ch.force_major);
                        if (out_ch.force_minor !== e.membrane.minor)
                            $error("force_minor exp %0d got %0d", e.membrane.minor,
                                   out_ch.force_minor);
                        if (out_ch.force_angle !== e.membrane.angle)
                            $error("force_angle exp %0d got %0d", e.membrane.angle,
                                   out_ch.force_angle);
                    end
                end
            end
        end
    end
endmodule

[bench/tb_top.sv]
// testbench top: reset, stimulus, threshold phases and verdict for the resolver
module tb_top;
    import psr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    int   cycle_cnt = 0;
    int   send_idle_pct, recv_stall_pct;
    int   hold_off;
    logic hold_req;
    logic hold_done;
    int   sent;

    psr_in_if  in_ch ();
    psr_out_if out_ch ();
    psr_cfg_if cfg_ch ();

    principal_stress_resolver u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    tb_psr_checker u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_ch   (cfg_ch),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    // long receiver hold-off, counted once on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_off <= 200;
            hold_done <= 1'b1;
        end else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // receiver: random stalls plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off > 0)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_data edge_val();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return t_data'($urandom_range(2000)) - 1000;
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_tensors(t_data mx, t_data my, t_data mxy,
                                t_data fx, t_data fy, t_data fxy);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.moment_x <= mx;
        in_ch.moment_y <= my;
        in_ch.moment_xy <= mxy;
        in_ch.force_x <= fx;
        in_ch.force_y <= fy;
        in_ch.force_xy <= fxy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_random();
        t_data a, s;
        // near-equal normals exercise the threshold gate
        a = edge_val();
        s = edge_val();
        if ($urandom_range(3) == 0)
            send_tensors(a, a + t_data'($urandom_range(40)) - 20, s,
                         edge_val(), edge_val(), edge_val());
        else
            send_tensors(edge_val(), edge_val(), edge_val(),
                         edge_val(), a, s);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_threshold(t_thr v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        t_thr thr_set [0:3];
        thr_set = '{16'd0, 16'hFFFF, 16'd5, 16'd300};
        in_ch.valid = 1'b0;
        {in_ch.moment_x, in_ch.moment_y, in_ch.moment_xy} = '0;
        {in_ch.force_x, in_ch.force_y, in_ch.force_xy} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        sent = 0;
        @(posedge i_clk iff i_rst_n);
        @(posedge i_clk);

        // directed: extremes, zero tensor, equal normals, near vertical angles
        send_tensors('0, '0, '0, '0, '0, '0);
        send_tensors(5, 5, 0, 100, 100, 7);
        send_tensors(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tensors(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_tensors(0, 1000, 1, 0, 1000, -1);
        send_tensors(-65536, 65536, 0, 65536, -65536, 0);
        send_tensors(0, 1, 0, 1, 0, 0);
        send_tensors(0, 2, 0, 2, 0, 0);
        send_tensors(0, 0, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000);
        send_tensors(32'sh8000_0000, 0, -1, 32'sh7FFF_FFFF, 0, 1);
        send_tensors(-1, -1, -1, 32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_tensors(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     -100, 100, 32'sh4000_0000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(thr_set[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (ph == 0) hold_req = 1'b1;
            for (int n = 0; n < 270; n++) begin
                if (n % 60 == 59 && ph != 2) begin
                    send_idle_pct = (send_idle_pct == 0) ? 0 : send_idle_pct;
                end
                send_random();
            end
            drain();
        end

        $display("sent %0d tensor pairs over four threshold settings, %0d results checked",
                 sent, results);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[principal_stress_resolver.f]
rtl/core/psr_pkg.sv
rtl/core/psr_if.sv
rtl/core/psr_tensor.sv
rtl/core/principal_stress_resolver.sv
rtl/core/psr_checker.sv
bench/psr_checker.sv
bench/tb_top.sv
